[design/i2crb_pkg.sv]
// Package for the register bank with auto-increment pointer.
// Holds the transfer payload types, operation codes and the control/status
// structs shared by the controller, the datapath and the top level.
package i2crb_pkg;

  // Operation codes carried in the operation field.
  typedef enum logic [2:0] {
    OP_BUS_BYTE   = 3'd0,
    OP_BUS_READ   = 3'd1,
    OP_LRD_BYTE   = 3'd2,
    OP_LRD_WORD   = 3'd3,
    OP_LWR_BYTE   = 3'd4,
    OP_LWR_WORD   = 3'd5
  } op_e;

  // Address source for a bank access.
  typedef enum logic [1:0] {
    SEL_PTR  = 2'd0,
    SEL_IDX  = 2'd1,
    SEL_IDX1 = 2'd2
  } addr_sel_e;

  // One input transfer.
  typedef struct packed {
    logic [2:0]  operation;
    logic        first_of_transfer;
    logic [7:0]  bus_byte;
    logic [7:0]  local_index;
    logic [15:0] local_value;
  } item_t;

  // One result transfer.
  typedef struct packed {
    logic [15:0] data;
    logic        last;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      load;
    logic      ptr_load;
    logic      ptr_adv;
    logic      wr_en;
    addr_sel_e wr_sel;
    logic      rd_en;
    addr_sel_e rd_sel;
    logic      emit;
    logic      last;
    logic      lo_cap;
    logic      word;
    logic      zero;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic idx_ok;
    logic word_ok;
  } status_t;

endpackage

[design/i2c_register_bank_auto_increment.sv]
// Top level of the byte register bank with auto-increment bus pointer.
// Instantiates i2crb_ctrl and i2crb_dpath; depends on i2crb_pkg.
//
// A transfer is taken when start is high and busy is low. Busy stays high
// in ST_PTR_LOAD, ST_BUS_WR, ST_LRD_B or ST_LWR_B for pointer loads, bus
// byte writes or local byte accesses, ST_*_W0 then ST_*_W1 for words,
// and ST_BURST for READ_LEN bank reads of a bus read, one per cycle via
// the single memory read port. Results pass the read data and result
// registers onto result_o, each for exactly one cycle marked by strobe;
// the receiver cannot stall, so it must take every strobed result. The
// bank reads zero after reset via per-entry valid bits, no clearing pass.
module i2c_register_bank_auto_increment import i2crb_pkg::*; #(
  parameter int NUM_REGS = 32,
  parameter int READ_LEN = 8
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  input  item_t   item_i,
  output logic    strobe,
  output result_t result_o
);

  cmd_t    cmd;
  status_t status;

  // Sequencer for each accepted transfer.
  i2crb_ctrl #(
    .READ_LEN (READ_LEN)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .first_i     (item_i.first_of_transfer),
    .operation_i (item_i.operation),
    .status_i    (status),
    .busy_o      (busy),
    .cmd_o       (cmd)
  );

  // Memory, pointer and result path.
  i2crb_dpath #(
    .NUM_REGS (NUM_REGS)
  ) u_dpath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_i),
    .cmd_i    (cmd),
    .status_o (status),
    .strobe_o (strobe),
    .result_o (result_o)
  );

endmodule

[design/i2crb_dpath.sv]
// Datapath of the register bank: byte memory with per-entry valid bits,
// bus pointer, read pipeline and result register. Depends on i2crb_pkg.
module i2crb_dpath import i2crb_pkg::*; #(
  parameter int NUM_REGS = 32
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  item_t   item_i,
  input  cmd_t    cmd_i,
  output status_t status_o,
  output logic    strobe_o,
  output result_t result_o
);

  localparam int PTR_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(NUM_REGS - 1);
  localparam logic [8:0] NREGS_9 = 9'(NUM_REGS);

  item_t            item_q;
  logic [PTR_W-1:0] ptr_q, ptr_d;
  logic [7:0]       bank_mem_q [NUM_REGS];
  logic             vld_q [NUM_REGS];
  logic [7:0]       rmem_q;
  logic             rvld_q;
  logic             p_emit_q, p_last_q, p_word_q, p_zero_q, p_lo_q;
  logic [7:0]       lo_q;
  logic             strobe_q;
  result_t          result_q;

  logic [PTR_W-1:0] idx_addr, idx1_addr, waddr, raddr;
  logic [7:0]       wdata, rbyte;
  logic [8:0]       idx_9, idx1_9;

  // Latch the accepted transfer.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= item_i;
    end
  end

  // Range checks on the local index.
  always_comb begin
    idx_9            = {1'b0, item_q.local_index};
    idx1_9           = idx_9 + 9'd1;
    status_o.idx_ok  = idx_9 < NREGS_9;
    status_o.word_ok = idx1_9 < NREGS_9;
    idx_addr         = item_q.local_index[PTR_W-1:0];
    idx1_addr        = idx_addr + PTR_W'(1);
  end

  // Write address and data selection.
  always_comb begin
    case (cmd_i.wr_sel)
      SEL_PTR: begin
        waddr = ptr_q;
        wdata = item_q.bus_byte;
      end
      SEL_IDX: begin
        waddr = idx_addr;
        wdata = item_q.local_value[7:0];
      end
      SEL_IDX1: begin
        waddr = idx1_addr;
        wdata = item_q.local_value[15:8];
      end
      default: begin
        waddr = ptr_q;
        wdata = item_q.bus_byte;
      end
    endcase
  end

  // Read address selection.
  always_comb begin
    case (cmd_i.rd_sel)
      SEL_PTR:  raddr = ptr_q;
      SEL_IDX:  raddr = idx_addr;
      SEL_IDX1: raddr = idx1_addr;
      default:  raddr = ptr_q;
    endcase
  end

  // Bus pointer: load from a pointer byte (zero if past the bank), or advance with wrap.
  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.ptr_load) begin
      if ({1'b0, item_q.bus_byte} < NREGS_9) begin
        ptr_d = item_q.bus_byte[PTR_W-1:0];
      end else begin
        ptr_d = '0;
      end
    end else if (cmd_i.ptr_adv) begin
      ptr_d = (ptr_q == PTR_MAX) ? '0 : ptr_q + PTR_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
    end else begin
      ptr_q <= ptr_d;
    end
  end

  // Byte memory with registered read data.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      bank_mem_q[waddr] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rmem_q <= bank_mem_q[raddr];
    end
  end

  // Valid bits: an entry never written reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        vld_q[i] <= 1'b0;
      end
      rvld_q <= 1'b0;
    end else begin
      if (cmd_i.wr_en) begin
        vld_q[waddr] <= 1'b1;
      end
      if (cmd_i.rd_en) begin
        rvld_q <= vld_q[raddr];
      end
    end
  end

  assign rbyte = rvld_q ? rmem_q : 8'h00;

  // Read pipeline flags are registered alongside the read data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_emit_q <= 1'b0;
      p_lo_q   <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      p_emit_q <= cmd_i.rd_en & cmd_i.emit;
      p_lo_q   <= cmd_i.rd_en & cmd_i.lo_cap;
      strobe_q <= p_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p_last_q <= cmd_i.last;
    p_word_q <= cmd_i.word;
    p_zero_q <= cmd_i.zero;
    if (p_lo_q) begin
      lo_q <= rbyte;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (p_emit_q) begin
      result_q.last <= p_last_q;
      if (p_zero_q) begin
        result_q.data <= 16'h0000;
      end else if (p_word_q) begin
        result_q.data <= {rbyte, lo_q};
      end else begin
        result_q.data <= {8'h00, rbyte};
      end
    end
  end

  assign strobe_o = strobe_q;
  assign result_o = result_q;

endmodule

[design/i2crb_ctrl.sv]
// Controller of the register bank: decodes each accepted transfer and
// sequences the datapath. Depends on i2crb_pkg.
module i2crb_ctrl import i2crb_pkg::*; #(
  parameter int READ_LEN = 8
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  logic    first_i,
  input  logic [2:0] operation_i,
  input  status_t status_i,
  output logic    busy_o,
  output cmd_t    cmd_o
);

  localparam int CNT_W = (READ_LEN > 1) ? $clog2(READ_LEN) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(READ_LEN - 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PTR_LOAD,
    ST_BUS_WR,
    ST_BURST,
    ST_LRD_B,
    ST_LRD_W0,
    ST_LRD_W1,
    ST_LWR_B,
    ST_LWR_W0,
    ST_LWR_W1
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             accept;

  assign busy_o = (state_q != ST_IDLE);
  assign accept = start_i & ~busy_o;

  // Next state and burst counter.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (accept) begin
          case (op_e'(operation_i))
            OP_BUS_BYTE: state_d = first_i ? ST_PTR_LOAD : ST_BUS_WR;
            OP_BUS_READ: state_d = ST_BURST;
            OP_LRD_BYTE: state_d = ST_LRD_B;
            OP_LRD_WORD: state_d = ST_LRD_W0;
            OP_LWR_BYTE: state_d = ST_LWR_B;
            OP_LWR_WORD: state_d = ST_LWR_W0;
            default:     state_d = ST_IDLE;
          endcase
        end
      end
      ST_BURST: begin
        if (cnt_q == CNT_LAST) begin
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_LRD_W0: state_d = ST_LRD_W1;
      ST_LWR_W0: state_d = ST_LWR_W1;
      default:   state_d = ST_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Commands to the datapath for each state.
  always_comb begin
    cmd_o        = '0;
    cmd_o.wr_sel = SEL_PTR;
    cmd_o.rd_sel = SEL_PTR;
    cmd_o.load   = accept;
    case (state_q)
      ST_PTR_LOAD: cmd_o.ptr_load = 1'b1;
      ST_BUS_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.ptr_adv = 1'b1;
      end
      ST_BURST: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.emit    = 1'b1;
        cmd_o.last    = (cnt_q == CNT_LAST);
        cmd_o.ptr_adv = 1'b1;
      end
      ST_LRD_B: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = SEL_IDX;
        cmd_o.emit   = 1'b1;
        cmd_o.last   = 1'b1;
        cmd_o.zero   = ~status_i.idx_ok;
      end
      ST_LRD_W0: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = SEL_IDX;
        cmd_o.lo_cap = 1'b1;
      end
      ST_LRD_W1: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = SEL_IDX1;
        cmd_o.emit   = 1'b1;
        cmd_o.last   = 1'b1;
        cmd_o.word   = 1'b1;
        cmd_o.zero   = ~status_i.word_ok;
      end
      ST_LWR_B: begin
        cmd_o.wr_en  = status_i.idx_ok;
        cmd_o.wr_sel = SEL_IDX;
      end
      ST_LWR_W0: begin
        cmd_o.wr_en  = status_i.word_ok;
        cmd_o.wr_sel = SEL_IDX;
      end
      ST_LWR_W1: begin
        cmd_o.wr_en  = status_i.word_ok;
        cmd_o.wr_sel = SEL_IDX1;
      end
      default: ;
    endcase
  end

endmodule

[verif/tb_i2c_register_bank_auto_increment.sv]
// Self-checking testbench for i2c_register_bank_auto_increment: directed and random
// bus and local transfers, checked against a behavioral model of the bank and pointer.
// Depends on i2crb_pkg and the top level of the register bank.
module tb_i2c_register_bank_auto_increment;
  import i2crb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_REGS = 32;
  localparam int READ_LEN = 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 500;
  // Operation codes the block leaves unused.
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  // Behavioral model of the bank and a queue of the results it predicts.
  class bank_scoreboard;
    logic [7:0] regs [NUM_REGS];
    int unsigned bus_ptr;
    result_t expected_reads [$];
    int errors;

    function new();
      foreach (regs[i]) regs[i] = 8'h00;
      bus_ptr = 0;
      errors = 0;
    endfunction

    // Update the model for one accepted transfer and queue its results.
    function void note_transfer(item_t it);
      int unsigned idx;
      int unsigned bbyte;
      result_t r;
      idx = {24'h000000, it.local_index};
      bbyte = {24'h000000, it.bus_byte};
      r.last = 1'b1;
      r.data = 16'h0000;
      case (it.operation)
        OP_BUS_BYTE: begin
          if (it.first_of_transfer) begin
            bus_ptr = (bbyte < NUM_REGS) ? bbyte : 0;
          end else begin
            regs[bus_ptr] = it.bus_byte;
            bus_ptr = (bus_ptr + 1 >= NUM_REGS) ? 0 : bus_ptr + 1;
          end
        end
        OP_BUS_READ: begin
          for (int k = 0; k < READ_LEN; k++) begin
            r.data = {8'h00, regs[bus_ptr]};
            r.last = (k == READ_LEN - 1);
            expected_reads.push_back(r);
            bus_ptr = (bus_ptr + 1 >= NUM_REGS) ? 0 : bus_ptr + 1;
          end
        end
        OP_LRD_BYTE: begin
          if (idx < NUM_REGS) r.data = {8'h00, regs[idx]};
          expected_reads.push_back(r);
        end
        OP_LRD_WORD: begin
          if (idx + 1 < NUM_REGS) r.data = {regs[idx + 1], regs[idx]};
          expected_reads.push_back(r);
        end
        OP_LWR_BYTE: begin
          if (idx < NUM_REGS) regs[idx] = it.local_value[7:0];
        end
        OP_LWR_WORD: begin
          if (idx + 1 < NUM_REGS) begin
            regs[idx] = it.local_value[7:0];
            regs[idx + 1] = it.local_value[15:8];
          end
        end
        default: ;
      endcase
    endfunction

    // Compare one strobed result with the oldest prediction.
    function void check_result(result_t got);
      result_t want;
      if (expected_reads.size() == 0) begin
        $error("unexpected result: data %h, last %b", got.data, got.last);
        errors++;
        return;
      end
      want = expected_reads.pop_front();
      if (got.data !== want.data) begin
        $error("data mismatch: expected %h, actual %h", want.data, got.data);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last mismatch: expected %b, actual %b", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start;
  logic busy;
  item_t item_i;
  logic strobe;
  result_t result_o;

  bank_scoreboard sb = new();
  int unsigned n_sent = 0;
  int unsigned cycles = 0;
  bit idle_on = 1'b1;

  i2c_register_bank_auto_increment #(
    .NUM_REGS(NUM_REGS),
    .READ_LEN(READ_LEN)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .item_i(item_i),
    .strobe(strobe),
    .result_o(result_o)
  );

  // Clock with a 4 ns period.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Watch accepted transfers and strobed results at each rising edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (strobe) sb.check_result(result_o);
      if (start && !busy) sb.note_transfer(item_i);
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Present one transfer at the falling edge and hold it until the block takes it.
  task automatic send_op(logic [2:0] op, logic first, logic [7:0] bbyte,
                         logic [7:0] idx, logic [15:0] val);
    item_t it;
    it.operation = op;
    it.first_of_transfer = first;
    it.bus_byte = bbyte;
    it.local_index = idx;
    it.local_value = val;
    @(negedge clk_i);
    while (idle_on && $urandom_range(99) < 37) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    n_sent++;
  endtask

  // Hold the sender off until every predicted result has come out.
  task automatic drain_results();
    @(negedge clk_i);
    start <= 1'b0;
    while (sb.expected_reads.size() != 0) @(posedge clk_i);
  endtask

  // Index for local accesses: mostly near the bank, sometimes anywhere.
  function automatic logic [7:0] pick_index();
    return ($urandom_range(9) < 8) ? 8'($urandom_range(NUM_REGS + 1)) : 8'($urandom);
  endfunction

  initial begin
    int unsigned pick;
    int unsigned burst;
    rst_ni = 1'b0;
    start = 1'b0;
    item_i = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part: reads after reset, range edges and pointer wrap.
    send_op(OP_BUS_READ, 1'b0, 8'h00, 8'h00, 16'h0000);
    send_op(OP_LRD_WORD, 1'b1, 8'hFF, 8'd0, 16'hFFFF);
    send_op(OP_LWR_BYTE, 1'b0, 8'h00, 8'd0, 16'hFFA5);
    send_op(OP_LWR_BYTE, 1'b0, 8'h00, 8'd31, 16'h005A);
    send_op(OP_LWR_BYTE, 1'b0, 8'h00, 8'd32, 16'h00EE);
    send_op(OP_LWR_BYTE, 1'b0, 8'h00, 8'd255, 16'h00DD);
    send_op(OP_LWR_WORD, 1'b0, 8'h00, 8'd30, 16'h1234);
    send_op(OP_LWR_WORD, 1'b0, 8'h00, 8'd31, 16'hBEEF);
    send_op(OP_LWR_WORD, 1'b0, 8'h00, 8'd255, 16'hCAFE);
    send_op(OP_LRD_BYTE, 1'b0, 8'h00, 8'd0, 16'h0000);
    send_op(OP_LRD_BYTE, 1'b0, 8'h00, 8'd31, 16'h0000);
    send_op(OP_LRD_BYTE, 1'b0, 8'h00, 8'd32, 16'h0000);
    send_op(OP_LRD_BYTE, 1'b0, 8'h00, 8'd255, 16'h0000);
    send_op(OP_LRD_WORD, 1'b0, 8'h00, 8'd30, 16'h0000);
    send_op(OP_LRD_WORD, 1'b0, 8'h00, 8'd31, 16'h0000);
    send_op(OP_BUS_BYTE, 1'b1, 8'd28, 8'h00, 16'h0000);
    send_op(OP_BUS_BYTE, 1'b0, 8'hFF, 8'h00, 16'h0000);
    send_op(OP_BUS_BYTE, 1'b0, 8'h00, 8'h00, 16'h0000);
    send_op(OP_BUS_BYTE, 1'b0, 8'h33, 8'h00, 16'h0000);
    send_op(OP_BUS_BYTE, 1'b0, 8'h44, 8'h00, 16'h0000);
    send_op(OP_BUS_BYTE, 1'b0, 8'h55, 8'h00, 16'h0000);
    // A pointer byte past the bank lands on register zero.
    send_op(OP_BUS_BYTE, 1'b1, 8'd32, 8'h00, 16'h0000);
    send_op(OP_BUS_READ, 1'b0, 8'h00, 8'h00, 16'h0000);
    send_op(OP_BUS_BYTE, 1'b1, 8'd255, 8'h00, 16'h0000);
    send_op(OP_SPARE_6, 1'b1, 8'hFF, 8'hFF, 16'hFFFF);
    send_op(OP_SPARE_7, 1'b0, 8'h00, 8'h00, 16'h0000);
    send_op(OP_BUS_READ, 1'b1, 8'hFF, 8'hFF, 16'hFFFF);
    drain_results();

    // Random part: mostly well-formed bus write transactions and local
    // accesses, with some fully random noise.
    n_sent = 0;
    while (n_sent < RANDOM_ITEMS) begin
      idle_on = !(n_sent >= 200 && n_sent < 300);
      pick = $urandom_range(99);
      if (pick < 40) begin
        send_op(OP_BUS_BYTE, 1'b1,
                ($urandom_range(9) < 8) ? 8'($urandom_range(NUM_REGS - 1)) : 8'($urandom),
                8'($urandom), 16'($urandom));
        burst = $urandom_range(1, 6);
        repeat (burst) begin
          send_op(OP_BUS_BYTE, 1'b0, 8'($urandom), 8'($urandom), 16'($urandom));
        end
        if ($urandom_range(1)) begin
          send_op(OP_BUS_READ, 1'($urandom), 8'($urandom), 8'($urandom), 16'($urandom));
        end
      end else if (pick < 55) begin
        send_op(OP_BUS_READ, 1'($urandom), 8'($urandom), 8'($urandom), 16'($urandom));
      end else if (pick < 90) begin
        send_op(3'($urandom_range(OP_LRD_BYTE, OP_LWR_WORD)), 1'($urandom), 8'($urandom),
                pick_index(), 16'($urandom));
      end else begin
        send_op(3'($urandom), 1'($urandom), 8'($urandom), 8'($urandom), 16'($urandom));
      end
      if ($urandom_range(39) == 0) drain_results();
    end

    // Wind down and let the last results come out.
    drain_results();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
